### rtl/alsd_pkg.sv
// shared constants and codes for the addressable led strip driver
package alsd_pkg;

    localparam int DEF_MAX_LEDS  = 256;
    localparam int DEF_DUTY_BITS = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int STRIP_LEN_W = 9;
    localparam int RESET_PER_W = 8;
    localparam int COLOR_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int BIT_POS_W   = 5;
    localparam int CMD_W       = 2;
    localparam int PHASE_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_STRIP_LEN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RGBW_MODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_DUTY      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_DUTY     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_PERIODS = 3'd4;

    localparam logic [STRIP_LEN_W-1:0] RST_STRIP_LEN     = 9'd1;
    localparam logic [RESET_PER_W-1:0] RST_RESET_PERIODS = 8'd50;

    localparam logic [CMD_W-1:0] CMD_SET_ONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ALL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DATA  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RESET = 2'd2;

    localparam logic [BIT_POS_W:0] BITS_RGB  = 6'd24;
    localparam logic [BIT_POS_W:0] BITS_RGBW = 6'd32;

endpackage

### rtl/addressable_led_strip_driver_top.sv
// addressable led strip driver: colour store, bit-serial frame sequencer and config registers
// a tick gives its result in the cycle after acceptance; busy stays high through the read and
// load states when the next led word is read from the colour store, set-one goes back to idle
// unless it starts a frame (then it also passes read and load), set-all walks the store in the
// fill state over the effective strip length, then read and load if it starts a frame with leds
// after reset busy is high while the colour store is cleared to zero
// results cannot be stalled: each is shown for exactly one cycle on result_valid
module addressable_led_strip_driver_top #(
    parameter int MAX_LEDS  = alsd_pkg::DEF_MAX_LEDS,
    parameter int DUTY_BITS = alsd_pkg::DEF_DUTY_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [alsd_pkg::CMD_W-1:0]         command,
    input  logic [alsd_pkg::CHAN_W-1:0]        led_index,
    input  logic [alsd_pkg::CHAN_W-1:0]        red,
    input  logic [alsd_pkg::CHAN_W-1:0]        green,
    input  logic [alsd_pkg::CHAN_W-1:0]        blue,
    input  logic [alsd_pkg::CHAN_W-1:0]        white,
    output logic                               result_valid,
    output logic [DUTY_BITS-1:0]               duty,
    output logic [alsd_pkg::PHASE_W-1:0]       phase,
    output logic                               frame_done,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [alsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [alsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W  = ($clog2(MAX_LEDS + 1) > alsd_pkg::STRIP_LEN_W)
                            ? $clog2(MAX_LEDS + 1) : alsd_pkg::STRIP_LEN_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    // config registers
    logic [alsd_pkg::STRIP_LEN_W-1:0] strip_len_reg;
    logic                             rgbw_mode_reg;
    logic [DUTY_BITS-1:0]             one_duty_reg;
    logic [DUTY_BITS-1:0]             zero_duty_reg;
    logic [alsd_pkg::RESET_PER_W-1:0] reset_periods_reg;

    // sequencer and frame state
    logic [2:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 walk_reg, walk_next;
    logic [alsd_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [CNT_W-1:0]                 ptr_reg, ptr_next;
    logic [alsd_pkg::BIT_POS_W-1:0]   bit_pos_reg, bit_pos_next;
    logic [alsd_pkg::RESET_PER_W-1:0] rcount_reg, rcount_next;
    logic                             pending_reg, pending_next;
    logic                             load_after_reg, load_after_next;
    logic [ADDR_W-1:0]                rd_ptr_reg, rd_ptr_next;

    // payload
    logic [alsd_pkg::COLOR_W-1:0]     shift_reg, shift_next;
    logic [alsd_pkg::COLOR_W-1:0]     fill_color_reg, fill_color_next;
    logic [alsd_pkg::COLOR_W-1:0]     rd_data_reg;
    logic                             result_valid_reg, result_valid_next;
    logic [DUTY_BITS-1:0]             duty_reg, duty_next;
    logic [alsd_pkg::PHASE_W-1:0]     res_phase_reg, res_phase_next;
    logic                             frame_done_reg, frame_done_next;

    logic [alsd_pkg::COLOR_W-1:0]     mem [MAX_LEDS];
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [alsd_pkg::COLOR_W-1:0]     mem_wdata;

    logic                             accept;
    logic [CNT_W-1:0]                 eff_count;
    logic [CNT_W-1:0]                 idx_ext;
    logic [CNT_W-1:0]                 ptr_inc;
    logic [alsd_pkg::COLOR_W-1:0]     color;
    logic [alsd_pkg::BIT_POS_W:0]     bit_pos_inc;
    logic [alsd_pkg::BIT_POS_W:0]     led_bits;
    logic [alsd_pkg::RESET_PER_W-1:0] rcount_inc;
    logic                             frame_go;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign eff_count = (CNT_W'(strip_len_reg) < CNT_W'(MAX_LEDS))
                       ? CNT_W'(strip_len_reg) : CNT_W'(MAX_LEDS);
    assign idx_ext   = CNT_W'(led_index);
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign color     = {green, red, blue, white};
    assign bit_pos_inc  = {1'b0, bit_pos_reg} + 6'd1;
    assign led_bits     = rgbw_mode_reg ? alsd_pkg::BITS_RGBW : alsd_pkg::BITS_RGB;
    assign rcount_inc   = rcount_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_len_reg     <= alsd_pkg::RST_STRIP_LEN;
            rgbw_mode_reg     <= 1'b0;
            one_duty_reg      <= '0;
            zero_duty_reg     <= '0;
            reset_periods_reg <= alsd_pkg::RST_RESET_PERIODS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                alsd_pkg::REG_STRIP_LEN:
                    strip_len_reg <= cfg_data[alsd_pkg::STRIP_LEN_W-1:0];
                alsd_pkg::REG_RGBW_MODE:
                    rgbw_mode_reg <= cfg_data[0];
                alsd_pkg::REG_ONE_DUTY:
                    one_duty_reg <= cfg_data[DUTY_BITS-1:0];
                alsd_pkg::REG_ZERO_DUTY:
                    zero_duty_reg <= cfg_data[DUTY_BITS-1:0];
                alsd_pkg::REG_RESET_PERIODS:
                    reset_periods_reg <= cfg_data[alsd_pkg::RESET_PER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        walk_next         = walk_reg;
        phase_next        = phase_reg;
        ptr_next          = ptr_reg;
        bit_pos_next      = bit_pos_reg;
        rcount_next       = rcount_reg;
        pending_next      = pending_reg;
        load_after_next   = load_after_reg;
        rd_ptr_next       = rd_ptr_reg;
        shift_next        = shift_reg;
        fill_color_next   = fill_color_reg;
        result_valid_next = 1'b0;
        duty_next         = duty_reg;
        res_phase_next    = res_phase_reg;
        frame_done_next   = frame_done_reg;
        mem_we            = 1'b0;
        mem_waddr         = ADDR_W'(walk_reg);
        mem_wdata         = '0;
        frame_go          = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (walk_reg == CNT_W'(MAX_LEDS - 1))
                begin
                    walk_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        alsd_pkg::CMD_SET_ONE:
                        begin
                            if (idx_ext < eff_count)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(led_index);
                                mem_wdata = color;
                                if (phase_reg == alsd_pkg::PH_IDLE)
                                    frame_go = 1'b1;
                                else if (phase_reg == alsd_pkg::PH_RESET ||
                                         {1'b0, idx_ext} <= ({1'b0, ptr_reg} + 1'b1))
                                    pending_next = 1'b1;
                            end
                        end
                        alsd_pkg::CMD_SET_ALL:
                        begin
                            fill_color_next = color;
                            walk_next       = '0;
                            state_next      = S_FILL;
                            if (phase_reg == alsd_pkg::PH_IDLE)
                                frame_go = 1'b1;
                            else
                                pending_next = 1'b1;
                        end
                        alsd_pkg::CMD_TICK:
                        begin
                            result_valid_next = 1'b1;
                            res_phase_next    = phase_reg;
                            duty_next         = '0;
                            frame_done_next   = 1'b0;
                            if (phase_reg == alsd_pkg::PH_DATA)
                            begin
                                duty_next    = shift_reg[alsd_pkg::COLOR_W-1]
                                               ? one_duty_reg : zero_duty_reg;
                                shift_next   = {shift_reg[alsd_pkg::COLOR_W-2:0], 1'b0};
                                bit_pos_next = bit_pos_inc[alsd_pkg::BIT_POS_W-1:0];
                                if (bit_pos_inc >= led_bits)
                                begin
                                    bit_pos_next = '0;
                                    ptr_next     = ptr_inc;
                                    if (ptr_inc >= eff_count)
                                    begin
                                        phase_next  = alsd_pkg::PH_RESET;
                                        rcount_next = '0;
                                    end
                                    else
                                    begin
                                        rd_ptr_next = ADDR_W'(ptr_inc);
                                        state_next  = S_READ;
                                    end
                                end
                            end
                            else if (phase_reg == alsd_pkg::PH_RESET)
                            begin
                                rcount_next = rcount_inc;
                                if (rcount_inc >= reset_periods_reg)
                                begin
                                    frame_done_next = 1'b1;
                                    phase_next      = alsd_pkg::PH_IDLE;
                                    ptr_next        = '0;
                                    bit_pos_next    = '0;
                                    rcount_next     = '0;
                                    if (pending_reg)
                                        frame_go = 1'b1;
                                end
                            end
                        end
                        alsd_pkg::CMD_UNUSED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                if (walk_reg < eff_count)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = fill_color_reg;
                    walk_next = walk_reg + CNT_W'(1);
                end
                else
                begin
                    walk_next  = '0;
                    state_next = load_after_reg ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                shift_next = rd_data_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // new frame: start from the first led, or go straight to the gap when empty
        if (frame_go)
        begin
            pending_next    = 1'b0;
            ptr_next        = '0;
            bit_pos_next    = '0;
            rcount_next     = '0;
            rd_ptr_next     = '0;
            load_after_next = (eff_count != '0);
            if (eff_count == '0)
            begin
                phase_next = alsd_pkg::PH_RESET;
            end
            else
            begin
                phase_next = alsd_pkg::PH_DATA;
                if (state_next == S_IDLE)
                    state_next = S_READ;
            end
        end
        else if (accept && command == alsd_pkg::CMD_SET_ALL)
        begin
            load_after_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            walk_reg         <= '0;
            phase_reg        <= alsd_pkg::PH_IDLE;
            ptr_reg          <= '0;
            bit_pos_reg      <= '0;
            rcount_reg       <= '0;
            pending_reg      <= 1'b0;
            load_after_reg   <= 1'b0;
            rd_ptr_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            walk_reg         <= walk_next;
            phase_reg        <= phase_next;
            ptr_reg          <= ptr_next;
            bit_pos_reg      <= bit_pos_next;
            rcount_reg       <= rcount_next;
            pending_reg      <= pending_next;
            load_after_reg   <= load_after_next;
            rd_ptr_reg       <= rd_ptr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg      <= shift_next;
        fill_color_reg <= fill_color_next;
        duty_reg       <= duty_next;
        res_phase_reg  <= res_phase_next;
        frame_done_reg <= frame_done_next;
    end

    // colour store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_ptr_reg];
    end

    assign result_valid = result_valid_reg;
    assign duty         = duty_reg;
    assign phase        = res_phase_reg;
    assign frame_done   = frame_done_reg;

endmodule

### sim/addressable_led_strip_driver_top_tb.sv
// testbench for the addressable led strip driver: directed and random commands checked against a predictor
module addressable_led_strip_driver_top_tb;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 125;
    localparam int PHASES        = 10;

    typedef enum logic [1:0] {
        BK_ITEM,
        BK_REG,
        BK_SETTLE
    } beat_kind_t;

    typedef struct {
        beat_kind_t                       kind;
        logic [alsd_pkg::CMD_W-1:0]       cmd;
        logic [alsd_pkg::CHAN_W-1:0]      idx;
        logic [alsd_pkg::CHAN_W-1:0]      red;
        logic [alsd_pkg::CHAN_W-1:0]      green;
        logic [alsd_pkg::CHAN_W-1:0]      blue;
        logic [alsd_pkg::CHAN_W-1:0]      white;
        logic [alsd_pkg::CFG_INDEX_W-1:0] reg_sel;
        logic [alsd_pkg::CFG_DATA_W-1:0]  reg_val;
        int unsigned                      idle_pct;
    } beat_t;

    typedef struct {
        logic [alsd_pkg::DEF_DUTY_BITS-1:0] duty;
        logic [alsd_pkg::PHASE_W-1:0]       phase;
        logic                               done;
        int unsigned                        stamp;
    } period_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [alsd_pkg::CMD_W-1:0]         command = '0;
    logic [alsd_pkg::CHAN_W-1:0]        led_index = '0;
    logic [alsd_pkg::CHAN_W-1:0]        red = '0;
    logic [alsd_pkg::CHAN_W-1:0]        green = '0;
    logic [alsd_pkg::CHAN_W-1:0]        blue = '0;
    logic [alsd_pkg::CHAN_W-1:0]        white = '0;
    logic                               result_valid;
    logic [alsd_pkg::DEF_DUTY_BITS-1:0] duty;
    logic [alsd_pkg::PHASE_W-1:0]       phase;
    logic                               frame_done;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [alsd_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [alsd_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    // predicted strip state
    logic [alsd_pkg::COLOR_W-1:0]     colour_mem [alsd_pkg::DEF_MAX_LEDS] = '{default: '0};
    logic [alsd_pkg::PHASE_W-1:0]     strip_phase = alsd_pkg::PH_IDLE;
    int unsigned                      pix_ptr = 0;
    int unsigned                      bit_pos = 0;
    logic [alsd_pkg::RESET_PER_W-1:0] gap_cnt = '0;
    logic                             redo_pending = 1'b0;
    logic [alsd_pkg::COLOR_W-1:0]     cur_word = '0;

    // register copies
    logic [alsd_pkg::STRIP_LEN_W-1:0] leds_reg = alsd_pkg::RST_STRIP_LEN;
    logic                             rgbw_reg = 1'b0;
    logic [alsd_pkg::CFG_DATA_W-1:0]  duty_one = '0;
    logic [alsd_pkg::CFG_DATA_W-1:0]  duty_zero = '0;
    logic [alsd_pkg::RESET_PER_W-1:0] gap_len = alsd_pkg::RST_RESET_PERIODS;

    beat_t       pending_beats [$];
    period_t     due_periods [$];
    beat_t       cur_beat;
    int unsigned cyc = 0;
    int unsigned gap_left = 0;
    int unsigned settle_cnt = 0;
    int unsigned fails = 0;
    int unsigned ticks_sent = 0;
    int unsigned writes_sent = 0;
    int unsigned regs_written = 0;
    int unsigned frames_seen = 0;

    addressable_led_strip_driver_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .white        (white),
        .result_valid (result_valid),
        .duty         (duty),
        .phase        (phase),
        .frame_done   (frame_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    function automatic int unsigned live_leds();
        return (leds_reg < alsd_pkg::DEF_MAX_LEDS) ? int'(leds_reg) : alsd_pkg::DEF_MAX_LEDS;
    endfunction

    task automatic open_frame();
        redo_pending = 1'b0;
        pix_ptr      = 0;
        bit_pos      = 0;
        gap_cnt      = '0;
        if (live_leds() == 0)
        begin
            strip_phase = alsd_pkg::PH_RESET;
            cur_word    = '0;
        end
        else
        begin
            strip_phase = alsd_pkg::PH_DATA;
            cur_word    = colour_mem[0];
        end
    endtask

    task automatic write_reg(input logic [alsd_pkg::CFG_INDEX_W-1:0] sel,
                             input logic [alsd_pkg::CFG_DATA_W-1:0] val);
        case (sel)
            alsd_pkg::REG_STRIP_LEN:     leds_reg = val[alsd_pkg::STRIP_LEN_W-1:0];
            alsd_pkg::REG_RGBW_MODE:     rgbw_reg = val[0];
            alsd_pkg::REG_ONE_DUTY:      duty_one = val;
            alsd_pkg::REG_ZERO_DUTY:     duty_zero = val;
            alsd_pkg::REG_RESET_PERIODS: gap_len = val[alsd_pkg::RESET_PER_W-1:0];
            default: ;
        endcase
        regs_written++;
    endtask

    task automatic advance_strip(input beat_t b);
        int unsigned                  leds;
        int unsigned                  per_led;
        int unsigned                  i;
        logic [alsd_pkg::COLOR_W-1:0] word;
        period_t                      res;
        leds      = live_leds();
        word      = {b.green, b.red, b.blue, b.white};
        res.duty  = '0;
        res.phase = strip_phase;
        res.done  = 1'b0;
        res.stamp = cyc;
        case (b.cmd)
            alsd_pkg::CMD_SET_ONE:
            begin
                writes_sent++;
                if (b.idx < leds)
                begin
                    colour_mem[b.idx] = word;
                    if (strip_phase == alsd_pkg::PH_IDLE)
                        open_frame();
                    else if (strip_phase == alsd_pkg::PH_RESET || b.idx <= pix_ptr + 1)
                        redo_pending = 1'b1;
                end
            end
            alsd_pkg::CMD_SET_ALL:
            begin
                writes_sent++;
                for (i = 0; i < leds; i++)
                    colour_mem[i] = word;
                if (strip_phase == alsd_pkg::PH_IDLE)
                    open_frame();
                else
                    redo_pending = 1'b1;
            end
            alsd_pkg::CMD_TICK:
            begin
                ticks_sent++;
                if (strip_phase == alsd_pkg::PH_DATA)
                begin
                    per_led  = rgbw_reg ? 32 : 24;
                    res.duty = cur_word[31 - (bit_pos % 32)] ? duty_one : duty_zero;
                    bit_pos++;
                    if (bit_pos >= per_led)
                    begin
                        bit_pos = 0;
                        pix_ptr++;
                        if (pix_ptr >= leds)
                        begin
                            strip_phase = alsd_pkg::PH_RESET;
                            gap_cnt     = '0;
                            cur_word    = '0;
                        end
                        else
                            cur_word = colour_mem[pix_ptr];
                    end
                end
                else if (strip_phase == alsd_pkg::PH_RESET)
                begin
                    gap_cnt = gap_cnt + 1'b1;
                    if (gap_cnt >= gap_len)
                    begin
                        res.done    = 1'b1;
                        strip_phase = alsd_pkg::PH_IDLE;
                        pix_ptr     = 0;
                        bit_pos     = 0;
                        gap_cnt     = '0;
                        if (redo_pending)
                            open_frame();
                    end
                end
                due_periods.push_back(res);
            end
            default: ;
        endcase
    endtask

    // driver: one beat at a time from the pending queue
    always @(posedge clk)
    begin
        beat_t nb;
        logic  n_start;
        logic  n_cfg_valid;
        if (rst_n)
        begin
            n_start     = start;
            n_cfg_valid = cfg_valid;
            if (start && !busy)
            begin
                advance_strip(cur_beat);
                n_start = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_reg(cfg_index, cfg_data);
                n_cfg_valid = 1'b0;
            end
            if (!n_start && !n_cfg_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_beats.size() > 0)
                begin
                    nb = pending_beats[0];
                    case (nb.kind)
                        BK_ITEM:
                        begin
                            void'(pending_beats.pop_front());
                            cur_beat  = nb;
                            n_start   = 1'b1;
                            command   <= nb.cmd;
                            led_index <= nb.idx;
                            red       <= nb.red;
                            green     <= nb.green;
                            blue      <= nb.blue;
                            white     <= nb.white;
                            gap_left  = ($urandom_range(0, 99) < nb.idle_pct) ?
                                        $urandom_range(1, 11) : 0;
                        end
                        BK_REG:
                        begin
                            void'(pending_beats.pop_front());
                            n_cfg_valid = 1'b1;
                            cfg_index   <= nb.reg_sel;
                            cfg_data    <= nb.reg_val;
                        end
                        default:
                        begin
                            if (due_periods.size() == 0 && !busy)
                            begin
                                settle_cnt++;
                                if (settle_cnt >= SETTLE_CYCLES)
                                begin
                                    settle_cnt = 0;
                                    void'(pending_beats.pop_front());
                                end
                            end
                            else
                                settle_cnt = 0;
                        end
                    endcase
                end
            end
            start     <= n_start;
            cfg_valid <= n_cfg_valid;
        end
    end

    // monitor: results only match ticks accepted at an earlier edge
    always @(posedge clk)
    begin
        period_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (due_periods.size() == 0 || due_periods[0].stamp >= cyc)
            begin
                $error("result with no tick waiting: duty %h phase %0d frame_done %b",
                       duty, phase, frame_done);
                fails++;
            end
            else
            begin
                want = due_periods.pop_front();
                if (duty !== want.duty)
                begin
                    $error("duty: expected %h, actual %h", want.duty, duty);
                    fails++;
                end
                if (phase !== want.phase)
                begin
                    $error("phase: expected %0d, actual %0d", want.phase, phase);
                    fails++;
                end
                if (frame_done !== want.done)
                begin
                    $error("frame_done: expected %b, actual %b", want.done, frame_done);
                    fails++;
                end
                if (want.done)
                    frames_seen++;
            end
        end
    end

    task automatic queue_item(input logic [alsd_pkg::CMD_W-1:0] cmd,
                              input logic [alsd_pkg::CHAN_W-1:0] idx,
                              input logic [alsd_pkg::CHAN_W-1:0] r,
                              input logic [alsd_pkg::CHAN_W-1:0] g,
                              input logic [alsd_pkg::CHAN_W-1:0] b,
                              input logic [alsd_pkg::CHAN_W-1:0] w,
                              input int unsigned pct);
        beat_t nb;
        nb          = '{kind: BK_ITEM, default: '0};
        nb.cmd      = cmd;
        nb.idx      = idx;
        nb.red      = r;
        nb.green    = g;
        nb.blue     = b;
        nb.white    = w;
        nb.idle_pct = pct;
        pending_beats.push_back(nb);
    endtask

    task automatic queue_reg(input logic [alsd_pkg::CFG_INDEX_W-1:0] sel,
                             input logic [alsd_pkg::CFG_DATA_W-1:0] val);
        beat_t nb;
        nb         = '{kind: BK_REG, default: '0};
        nb.reg_sel = sel;
        nb.reg_val = val;
        pending_beats.push_back(nb);
    endtask

    task automatic queue_settle();
        beat_t nb;
        nb = '{kind: BK_SETTLE, default: '0};
        pending_beats.push_back(nb);
    endtask

    function automatic logic [alsd_pkg::CHAN_W-1:0] pick_chan();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return alsd_pkg::CHAN_W'($urandom());
    endfunction

    task automatic queue_random_item(input int unsigned leds, input int unsigned pct);
        int unsigned                 roll;
        logic [alsd_pkg::CMD_W-1:0]  op;
        logic [alsd_pkg::CHAN_W-1:0] idx;
        roll = $urandom_range(0, 99);
        if (roll < 66)
            op = alsd_pkg::CMD_TICK;
        else if (roll < 84)
            op = alsd_pkg::CMD_SET_ONE;
        else if (roll < 95)
            op = alsd_pkg::CMD_SET_ALL;
        else
            op = alsd_pkg::CMD_UNUSED;
        // mostly near the strip, so that writes land on sent and upcoming leds
        if ($urandom_range(0, 3) == 0)
            idx = alsd_pkg::CHAN_W'($urandom_range(0, 255));
        else
            idx = alsd_pkg::CHAN_W'($urandom_range(0, (leds < 255) ? leds + 1 : 255));
        queue_item(op, idx, pick_chan(), pick_chan(), pick_chan(), pick_chan(), pct);
    endtask

    initial
    begin
        int unsigned p;
        int unsigned leds_cfg;
        int unsigned live;
        int unsigned pct;
        int unsigned k;
        queue_settle();
        queue_reg(alsd_pkg::REG_STRIP_LEN, 16'd0);
        queue_reg(alsd_pkg::REG_RESET_PERIODS, 16'd0);
        queue_reg(alsd_pkg::REG_ONE_DUTY, 16'hFFFF);
        queue_reg(alsd_pkg::REG_ZERO_DUTY, 16'h0000);
        queue_reg(alsd_pkg::REG_RGBW_MODE, 16'd1);
        queue_item(alsd_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 30);
        queue_item(alsd_pkg::CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 30);
        queue_item(alsd_pkg::CMD_SET_ONE, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 30);
        queue_item(alsd_pkg::CMD_SET_ALL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 30);
        queue_item(alsd_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 30);
        queue_item(alsd_pkg::CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 30);
        queue_settle();
        queue_reg(alsd_pkg::REG_STRIP_LEN, 16'd1);
        queue_reg(alsd_pkg::REG_RESET_PERIODS, 16'd2);
        queue_reg(alsd_pkg::REG_RGBW_MODE, 16'd0);
        queue_item(alsd_pkg::CMD_SET_ONE, 8'h00, 8'h00, 8'hFF, 8'hA5, 8'h5A, 30);
        queue_item(alsd_pkg::CMD_SET_ONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 30);
        for (k = 0; k < 6; k++)
            queue_item(alsd_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 30);
        queue_item(alsd_pkg::CMD_SET_ONE, 8'h00, 8'hC3, 8'h3C, 8'h0F, 8'hF0, 30);
        queue_item(alsd_pkg::CMD_SET_ALL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 30);
        for (k = 0; k < 6; k++)
            queue_item(alsd_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 30);

        for (p = 0; p < PHASES; p++)
        begin
            queue_settle();
            case (p)
                1:       leds_cfg = 256;
                4:       leds_cfg = 511;
                6:       leds_cfg = 0;
                default: leds_cfg = $urandom_range(1, 4);
            endcase
            live = (leds_cfg < alsd_pkg::DEF_MAX_LEDS) ? leds_cfg : alsd_pkg::DEF_MAX_LEDS;
            queue_reg(alsd_pkg::REG_STRIP_LEN, alsd_pkg::CFG_DATA_W'(leds_cfg));
            queue_reg(alsd_pkg::REG_RGBW_MODE,
                      (p == 1) ? 16'd1 : alsd_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            if (p == 1)
                queue_reg(alsd_pkg::REG_RESET_PERIODS, 16'd255);
            else if (p == 6)
                queue_reg(alsd_pkg::REG_RESET_PERIODS, 16'd0);
            else
                queue_reg(alsd_pkg::REG_RESET_PERIODS,
                          alsd_pkg::CFG_DATA_W'($urandom_range(1, 6)));
            queue_reg(alsd_pkg::REG_ONE_DUTY, (p == 2) ? 16'h0000 : (p == 3) ? 16'hFFFF :
                                              alsd_pkg::CFG_DATA_W'($urandom()));
            queue_reg(alsd_pkg::REG_ZERO_DUTY, (p == 2) ? 16'hFFFF : (p == 3) ? 16'h0000 :
                                               alsd_pkg::CFG_DATA_W'($urandom()));
            // busy and quiet phases alternate, the last one runs flat out
            pct = (p == PHASES - 1) ? 0 : (p % 2 == 1) ? 10 : 35;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                queue_random_item(live, pct);
                if (pct != 0 && $urandom_range(0, 199) == 0)
                    queue_settle();
            end
        end
        queue_settle();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_beats.size() != 0 || start || cfg_valid)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (due_periods.size() != 0)
        begin
            $error("%0d expected periods never came out", due_periods.size());
            fails++;
        end
        $display("covered %0d ticks, %0d colour writes and %0d register writes", ticks_sent,
                 writes_sent, regs_written);
        $display("%0d complete frames seen across %0d register settings", frames_seen,
                 PHASES + 2);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(20 * 3000000);
        $display("FAILURE");
        $finish;
    end

endmodule
